// File: hw/rtl/mscc_pkg.sv
// Package of shared types, widths and codes for the minimum square count classifier.
package mscc_pkg;

    // Widths of the item fields.
    localparam int VALUE_W  = 17;
    localparam int BIN_W    = 3;
    localparam int STATUS_W = 2;
    localparam int MODE_W   = 2;

    // Magnitudes above 2^MAG_BITS - 1 are out of range.
    localparam int MAG_BITS = 16;
    // The integer square root of an in-range magnitude fits in half its bits.
    localparam int ROOT_BITS = (MAG_BITS + 1) / 2;
    localparam int K_W       = (ROOT_BITS > 1) ? $clog2(ROOT_BITS) : 1;
    // Running sums of two squares need two guard bits above the magnitude.
    localparam int SUM_W     = 2 * ROOT_BITS + 2;

    localparam logic [VALUE_W-1:0] MAG_LIMIT = VALUE_W'((64'd1 << MAG_BITS) - 64'd1);

    // Result status codes.
    localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_DROPPED = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_ERROR   = 2'd2;

    // Handling of negative words.
    localparam logic [MODE_W-1:0] MODE_IGNORE_SIGN = 2'd0;
    localparam logic [MODE_W-1:0] MODE_DROP        = 2'd1;
    localparam logic [MODE_W-1:0] MODE_AS_ZERO     = 2'd2;
    localparam logic [MODE_W-1:0] MODE_REPORT      = 2'd3;

    // Bin values.
    localparam logic [BIN_W-1:0] BIN_ZERO  = 3'd0;
    localparam logic [BIN_W-1:0] BIN_ONE   = 3'd1;
    localparam logic [BIN_W-1:0] BIN_TWO   = 3'd2;
    localparam logic [BIN_W-1:0] BIN_THREE = 3'd3;
    localparam logic [BIN_W-1:0] BIN_FOUR  = 3'd4;

    // Top level control states.
    typedef enum logic [1:0] {
        TS_IDLE,
        TS_RUN,
        TS_HOLD
    } top_state_t;

    // Sequencer states of the classification engine.
    typedef enum logic [2:0] {
        ES_IDLE,
        ES_ROOT,
        ES_SQCHK,
        ES_PAIR,
        ES_LEG,
        ES_DONE
    } eng_state_t;

    // Compare flags from the shared adder.
    typedef struct packed {
        logic lt;
        logic eq;
    } cmp_flags_t;

    // Response of the engine to the top level.
    typedef struct packed {
        logic             busy;
        logic             done;
        logic [BIN_W-1:0] bin;
    } eng_resp_t;

endpackage

// File: hw/rtl/mscc_unit.sv
// Shared adder with a compare of the sum against the magnitude under test.
module mscc_unit (
    input  logic [mscc_pkg::SUM_W-1:0]    opa,
    input  logic [mscc_pkg::SUM_W-1:0]    opb,
    input  logic [mscc_pkg::MAG_BITS-1:0] n,
    output logic [mscc_pkg::SUM_W-1:0]    sum,
    output mscc_pkg::cmp_flags_t          flags
);

    logic [mscc_pkg::SUM_W-1:0] n_ext;

    // One add, then an unsigned compare of the result with the magnitude.
    always_comb begin
        n_ext    = mscc_pkg::SUM_W'(n);
        sum      = opa + opb;
        flags.lt = (sum < n_ext);
        flags.eq = (sum == n_ext);
    end

endmodule

// File: hw/rtl/mscc_engine.sv
// Sequencer that finds the least square count of a magnitude with the shared adder.
module mscc_engine (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start,
    input  logic [mscc_pkg::MAG_BITS-1:0] n,
    output mscc_pkg::eng_resp_t           resp
);

    mscc_pkg::eng_state_t state_reg, state_next;

    logic [mscc_pkg::MAG_BITS-1:0]  n_reg, n_next;
    logic [mscc_pkg::SUM_W-1:0]     s_reg, s_next;
    logic [mscc_pkg::ROOT_BITS-1:0] root_reg, root_next;
    logic [mscc_pkg::ROOT_BITS-1:0] a_reg, a_next;
    logic [mscc_pkg::K_W-1:0]       k_reg, k_next;
    logic [mscc_pkg::MAG_BITS-1:0]  m_reg, m_next;
    logic [mscc_pkg::BIN_W-1:0]     bin_reg, bin_next;
    mscc_pkg::cmp_flags_t           flags_reg, flags_next;

    logic [mscc_pkg::SUM_W-1:0] opa, opb, sum;
    logic [mscc_pkg::SUM_W-1:0] trial_add, step_add;
    mscc_pkg::cmp_flags_t       flags;

    mscc_unit u_unit (
        .opa   (opa),
        .opb   (opb),
        .n     (n_reg),
        .sum   (sum),
        .flags (flags)
    );

    // Next state of the sequencer.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            mscc_pkg::ES_IDLE: begin
                if (start) begin
                    state_next = (n == '0) ? mscc_pkg::ES_DONE : mscc_pkg::ES_ROOT;
                end
            end
            mscc_pkg::ES_ROOT: begin
                if (k_reg == '0) begin
                    state_next = mscc_pkg::ES_SQCHK;
                end
            end
            mscc_pkg::ES_SQCHK: begin
                state_next = flags.eq ? mscc_pkg::ES_DONE : mscc_pkg::ES_PAIR;
            end
            mscc_pkg::ES_PAIR: begin
                if (flags_reg.eq) begin
                    state_next = mscc_pkg::ES_DONE;
                end else if (a_reg == root_reg) begin
                    state_next = mscc_pkg::ES_LEG;
                end
            end
            mscc_pkg::ES_LEG: begin
                if (m_reg[1:0] != 2'b00) begin
                    state_next = mscc_pkg::ES_DONE;
                end
            end
            mscc_pkg::ES_DONE: begin
                state_next = mscc_pkg::ES_IDLE;
            end
            default: begin
                state_next = mscc_pkg::ES_IDLE;
            end
        endcase
    end

    // Operand selection for the shared adder, and the response to the top level.
    always_comb begin
        // (root + bit)^2 = root^2 + root * 2^(k+1) + 2^(2k); the two added terms share no bits.
        trial_add = (mscc_pkg::SUM_W'(root_reg) << (k_reg + 1'b1))
                  | (mscc_pkg::SUM_W'(1) << {k_reg, 1'b0});
        // Step the pair sum: a up adds 2a+1, b down subtracts 2b-1.
        step_add  = flags_reg.lt ? mscc_pkg::SUM_W'({a_reg, 1'b1})
                                 : (mscc_pkg::SUM_W'(1) - (mscc_pkg::SUM_W'(root_reg) << 1));
        opa = s_reg;
        opb = '0;
        unique case (state_reg)
            mscc_pkg::ES_ROOT: opb = trial_add;
            mscc_pkg::ES_PAIR: opb = step_add;
            default:           opb = '0;
        endcase
        resp.busy = (state_reg != mscc_pkg::ES_IDLE);
        resp.done = (state_reg == mscc_pkg::ES_DONE);
        resp.bin  = bin_reg;
    end

    // Datapath updates. In the pair search root_reg serves as the upper index b.
    always_comb begin
        n_next     = n_reg;
        s_next     = s_reg;
        root_next  = root_reg;
        a_next     = a_reg;
        k_next     = k_reg;
        m_next     = m_reg;
        bin_next   = bin_reg;
        flags_next = flags_reg;
        unique case (state_reg)
            mscc_pkg::ES_IDLE: begin
                if (start) begin
                    n_next    = n;
                    s_next    = '0;
                    root_next = '0;
                    k_next    = mscc_pkg::K_W'(mscc_pkg::ROOT_BITS - 1);
                    bin_next  = mscc_pkg::BIN_ZERO;
                end
            end
            mscc_pkg::ES_ROOT: begin
                // Keep the trial bit when its square does not pass the magnitude.
                if (flags.lt || flags.eq) begin
                    s_next    = sum;
                    root_next = root_reg | (mscc_pkg::ROOT_BITS'(1) << k_reg);
                end
                k_next = k_reg - 1'b1;
            end
            mscc_pkg::ES_SQCHK: begin
                // Perfect square test, then start the pair search at (0, root).
                if (flags.eq) begin
                    bin_next = mscc_pkg::BIN_ONE;
                end
                a_next     = '0;
                flags_next = flags;
            end
            mscc_pkg::ES_PAIR: begin
                if (flags_reg.eq) begin
                    bin_next = mscc_pkg::BIN_TWO;
                end else if (a_reg == root_reg) begin
                    m_next = n_reg;
                end else begin
                    if (flags_reg.lt) begin
                        a_next = a_reg + 1'b1;
                    end else begin
                        root_next = root_reg - 1'b1;
                    end
                    s_next     = sum;
                    flags_next = flags;
                end
            end
            mscc_pkg::ES_LEG: begin
                // Strip factors of four, then test for the form 8b + 7.
                if (m_reg[1:0] == 2'b00) begin
                    m_next = m_reg >> 2;
                end else begin
                    bin_next = (m_reg[2:0] == 3'b111) ? mscc_pkg::BIN_FOUR
                                                      : mscc_pkg::BIN_THREE;
                end
            end
            default: begin
                bin_next = bin_reg;
            end
        endcase
    end

    // State and datapath registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= mscc_pkg::ES_IDLE;
        end else begin
            state_reg <= state_next;
        end
        n_reg     <= n_next;
        s_reg     <= s_next;
        root_reg  <= root_next;
        a_reg     <= a_next;
        k_reg     <= k_next;
        m_reg     <= m_next;
        bin_reg   <= bin_next;
        flags_reg <= flags_next;
    end

endmodule

// File: hw/rtl/min_square_count_classifier_unit.sv
// Top level of the minimum square count classifier with its handshakes and mode register.
//
// Each word carries a signed 17-bit value and gives one result: the least number of
// perfect squares that sum to its magnitude (bin 0 to 4), the value echoed, and a status.
// The block works on one word at a time; s_ready is low from acceptance until the result
// has moved into the output register, which may still be waiting for m_ready. Words that
// need no search (zero, out of range, or negative outside ignore-sign mode) go straight to
// the hold state. Otherwise the engine, built around the shared adder, runs the square
// root, the perfect square test, the two-square pair search and the Legendre test in
// turn, stopping once the bin is known, and then returns the bin.
// The negative mode register is written through the cfg channel, which is always ready.
module min_square_count_classifier_unit (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [mscc_pkg::MODE_W-1:0]           cfg_data,
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  logic signed [mscc_pkg::VALUE_W-1:0]   s_value,
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic [mscc_pkg::BIN_W-1:0]            m_bin,
    output logic signed [mscc_pkg::VALUE_W-1:0]   m_value_out,
    output logic [mscc_pkg::STATUS_W-1:0]         m_status
);

    mscc_pkg::top_state_t state_reg, state_next;

    logic [mscc_pkg::MODE_W-1:0]          mode_reg;
    logic [mscc_pkg::VALUE_W-1:0]         value_reg, value_next;
    logic [mscc_pkg::BIN_W-1:0]           res_bin_reg, res_bin_next;
    logic [mscc_pkg::STATUS_W-1:0]        res_status_reg, res_status_next;
    logic                                 m_valid_reg, m_valid_next;
    logic [mscc_pkg::BIN_W-1:0]           m_bin_reg, m_bin_next;
    logic [mscc_pkg::VALUE_W-1:0]         m_value_reg, m_value_next;
    logic [mscc_pkg::STATUS_W-1:0]        m_status_reg, m_status_next;

    logic                                 accept;
    logic                                 negative;
    logic [mscc_pkg::VALUE_W-1:0]         mag;
    logic                                 need_run;
    logic                                 out_free;
    logic                                 start;
    logic [mscc_pkg::BIN_W-1:0]           imm_bin;
    logic [mscc_pkg::STATUS_W-1:0]        imm_status;
    mscc_pkg::eng_resp_t                  resp;

    mscc_engine u_engine (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (start),
        .n       (mag[mscc_pkg::MAG_BITS-1:0]),
        .resp    (resp)
    );

    // Sign handling and the immediate result for words that need no search.
    always_comb begin
        accept     = s_valid && s_ready;
        negative   = s_value[mscc_pkg::VALUE_W-1];
        mag        = negative ? (~s_value + 1'b1) : s_value;
        need_run   = 1'b0;
        imm_bin    = mscc_pkg::BIN_ZERO;
        imm_status = mscc_pkg::STATUS_OK;
        if (negative && (mode_reg == mscc_pkg::MODE_DROP)) begin
            imm_status = mscc_pkg::STATUS_DROPPED;
        end else if (negative && (mode_reg == mscc_pkg::MODE_REPORT)) begin
            imm_status = mscc_pkg::STATUS_ERROR;
        end else if (negative && (mode_reg == mscc_pkg::MODE_AS_ZERO)) begin
            imm_status = mscc_pkg::STATUS_OK;
        end else if (mag > mscc_pkg::MAG_LIMIT) begin
            imm_status = mscc_pkg::STATUS_ERROR;
        end else if (mag != '0) begin
            need_run = 1'b1;
        end
        start = accept && need_run;
    end

    // Next state of the control.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            mscc_pkg::TS_IDLE: begin
                if (accept) begin
                    state_next = need_run ? mscc_pkg::TS_RUN : mscc_pkg::TS_HOLD;
                end
            end
            mscc_pkg::TS_RUN: begin
                if (resp.done) begin
                    state_next = mscc_pkg::TS_HOLD;
                end
            end
            mscc_pkg::TS_HOLD: begin
                if (out_free) begin
                    state_next = mscc_pkg::TS_IDLE;
                end
            end
            default: begin
                state_next = mscc_pkg::TS_IDLE;
            end
        endcase
    end

    // Handshake outputs, pending result and the output register.
    always_comb begin
        cfg_ready       = 1'b1;
        s_ready         = (state_reg == mscc_pkg::TS_IDLE);
        out_free        = !m_valid_reg || m_ready;
        value_next      = value_reg;
        res_bin_next    = res_bin_reg;
        res_status_next = res_status_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        m_bin_next      = m_bin_reg;
        m_value_next    = m_value_reg;
        m_status_next   = m_status_reg;
        unique case (state_reg)
            mscc_pkg::TS_IDLE: begin
                if (accept) begin
                    value_next      = s_value;
                    res_bin_next    = imm_bin;
                    res_status_next = imm_status;
                end
            end
            mscc_pkg::TS_RUN: begin
                if (resp.done) begin
                    res_bin_next    = resp.bin;
                    res_status_next = mscc_pkg::STATUS_OK;
                end
            end
            mscc_pkg::TS_HOLD: begin
                if (out_free) begin
                    m_valid_next  = 1'b1;
                    m_bin_next    = res_bin_reg;
                    m_value_next  = value_reg;
                    m_status_next = res_status_reg;
                end
            end
            default: begin
                m_valid_next = m_valid_reg && !m_ready;
            end
        endcase
        m_valid     = m_valid_reg;
        m_bin       = m_bin_reg;
        m_value_out = m_value_reg;
        m_status    = m_status_reg;
    end

    // Control and payload registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= mscc_pkg::TS_IDLE;
            mode_reg    <= mscc_pkg::MODE_IGNORE_SIGN;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            if (cfg_valid && cfg_ready) begin
                mode_reg <= cfg_data;
            end
        end
        value_reg      <= value_next;
        res_bin_reg    <= res_bin_next;
        res_status_reg <= res_status_next;
        m_bin_reg      <= m_bin_next;
        m_value_reg    <= m_value_next;
        m_status_reg   <= m_status_next;
    end

    // The engine reports completion only while the control waits for it.
    assert property (@(posedge aclk) disable iff (!aresetn)
        resp.done |-> (state_reg == mscc_pkg::TS_RUN))
        else $error("engine finished outside a run");

    // A new search starts only when the engine is free.
    assert property (@(posedge aclk) disable iff (!aresetn)
        start |-> !resp.busy)
        else $error("engine started while busy");

    // A searched magnitude is nonzero, so its bin is between one and four.
    assert property (@(posedge aclk) disable iff (!aresetn)
        resp.done |-> (resp.bin != mscc_pkg::BIN_ZERO) && (resp.bin <= mscc_pkg::BIN_FOUR))
        else $error("engine bin out of range");

    // Dropped and errored words always carry bin zero.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && (m_status_reg != mscc_pkg::STATUS_OK)) |->
            (m_bin_reg == mscc_pkg::BIN_ZERO))
        else $error("nonzero bin on a dropped or error word");

endmodule

// File: test/min_square_count_classifier_unit_test.sv
// Self-checking testbench for the minimum square count classifier unit.
`timescale 1ns / 100ps

module min_square_count_classifier_unit_test;

    localparam int VALUE_W      = mscc_pkg::VALUE_W;
    localparam int BIN_W        = mscc_pkg::BIN_W;
    localparam int STATUS_W     = mscc_pkg::STATUS_W;
    localparam int MODE_W       = mscc_pkg::MODE_W;
    localparam int MAG_BITS     = mscc_pkg::MAG_BITS;
    localparam int CLK_PERIOD   = 20;
    localparam int RESET_CYCLES = 7;
    localparam int MAX_GAP      = 12;
    localparam int SETTLE_DELAY = 16;
    localparam int HOLD_OFF     = 500;
    localparam int STALL_LIMIT  = 4000;
    localparam int MAG_MAX      = (1 << MAG_BITS) - 1;
    localparam int PHASE_WORDS  = 170;

    // One expected result word.
    typedef struct {
        logic [BIN_W-1:0]          bin;
        logic signed [VALUE_W-1:0] value;
        logic [STATUS_W-1:0]       status;
    } class_result_t;

    logic                       aclk = 1'b0;
    logic                       aresetn;
    logic                       cfg_valid;
    logic                       cfg_ready;
    logic [MODE_W-1:0]          cfg_data;
    logic                       s_valid;
    logic                       s_ready;
    logic signed [VALUE_W-1:0]  s_value;
    logic                       m_valid;
    logic                       m_ready;
    logic [BIN_W-1:0]           m_bin;
    logic signed [VALUE_W-1:0]  m_value_out;
    logic [STATUS_W-1:0]        m_status;

    // Predictor state: its own copy of the mode register and a table of perfect squares.
    logic [MODE_W-1:0]          neg_mode;
    bit                         square_map [0:MAG_MAX];
    class_result_t              pending_results [$];

    // Shared control between the stimulus, the result sink and the checker.
    bit                         steady_flow;
    int                         hold_request;
    int                         fault_count;
    int                         words_sent;
    int                         results_seen;
    int                         mode_writes;
    int                         bin_tally [0:7];
    int                         status_tally [0:3];
    int                         idle_cycles;

    min_square_count_classifier_unit u_top (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_data    (cfg_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_value     (s_value),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_bin       (m_bin),
        .m_value_out (m_value_out),
        .m_status    (m_status)
    );

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    // Least number of squares summing to n, by square tests and the three-square rule.
    function automatic logic [BIN_W-1:0] square_count_of(input int n);
        int rest;
        if (n == 0) return mscc_pkg::BIN_ZERO;
        if (square_map[n]) return mscc_pkg::BIN_ONE;
        for (int a = 1; a * a <= n; a++) begin
            if (square_map[n - a * a]) return mscc_pkg::BIN_TWO;
        end
        rest = n;
        while ((rest & 3) == 0) rest = rest >> 2;
        if ((rest & 7) == 7) return mscc_pkg::BIN_FOUR;
        return mscc_pkg::BIN_THREE;
    endfunction

    // Expected result of one word under the current negative mode.
    function automatic class_result_t classify_word(input logic signed [VALUE_W-1:0] word);
        class_result_t res;
        bit            search;
        int            mag;
        res.bin    = mscc_pkg::BIN_ZERO;
        res.value  = word;
        res.status = mscc_pkg::STATUS_OK;
        search     = 1'b1;
        if (word < 0) begin
            case (neg_mode)
                mscc_pkg::MODE_IGNORE_SIGN: search = 1'b1;
                mscc_pkg::MODE_DROP: begin
                    search     = 1'b0;
                    res.status = mscc_pkg::STATUS_DROPPED;
                end
                mscc_pkg::MODE_AS_ZERO: search = 1'b0;
                default: begin
                    search     = 1'b0;
                    res.status = mscc_pkg::STATUS_ERROR;
                end
            endcase
        end
        if (search) begin
            mag = (word < 0) ? -int'(word) : int'(word);
            if (mag > MAG_MAX) res.status = mscc_pkg::STATUS_ERROR;
            else res.bin = square_count_of(mag);
        end
        return res;
    endfunction

    // Random word, weighted towards squares, sums of two squares and four-square forms.
    function automatic logic signed [VALUE_W-1:0] random_word();
        int                        pick;
        int                        mag;
        int                        k;
        int                        shift;
        logic signed [VALUE_W-1:0] word;
        pick = $urandom_range(0, 99);
        if (pick < 30) return VALUE_W'($urandom);
        if (pick < 50) begin
            mag = $urandom_range(0, 400);
        end else if (pick < 65) begin
            k   = $urandom_range(0, 255);
            mag = k * k;
            case ($urandom_range(0, 2))
                0: if (mag > 0) mag = mag - 1;
                2: if (mag < MAG_MAX) mag = mag + 1;
                default: ;
            endcase
        end else if (pick < 77) begin
            mag = $urandom_range(1, 180) ** 2 + $urandom_range(1, 180) ** 2;
        end else if (pick < 92) begin
            shift = 2 * $urandom_range(0, 6);
            k     = $urandom_range(0, ((MAG_MAX >> shift) - 7) / 8);
            mag   = (8 * k + 7) << shift;
        end else begin
            case ($urandom_range(0, 3))
                0: return '0;
                1: return VALUE_W'(MAG_MAX);
                2: return VALUE_W'(-MAG_MAX);
                default: return VALUE_W'(-(MAG_MAX + 1));
            endcase
        end
        word = VALUE_W'(mag);
        if ($urandom_range(0, 1) != 0) word = -word;
        return word;
    endfunction

    // Offer one word after a random gap, or none in steady flow, and record its expected result once accepted.
    task automatic send_word(input logic signed [VALUE_W-1:0] word);
        int gap;
        gap = steady_flow ? 0 : $urandom_range(0, MAX_GAP);
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_value <= word;
        do @(posedge aclk); while (!(s_valid && s_ready));
        pending_results.insert(pending_results.size(), classify_word(word));
        words_sent++;
    endtask

    // Stop offering, wait for every expected result and let the block settle.
    task automatic await_all_results();
        s_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (SETTLE_DELAY) @(posedge aclk);
    endtask

    // Write the negative mode register; only called while the block is idle.
    task automatic write_mode(input logic [MODE_W-1:0] mode);
        cfg_valid <= 1'b1;
        cfg_data  <= mode;
        do @(posedge aclk); while (!(cfg_valid && cfg_ready));
        cfg_valid <= 1'b0;
        neg_mode = mode;
        mode_writes++;
    endtask

    // Extremes and bin boundaries under the mode left by reset.
    task automatic test_reset_mode_directed();
        int words [16] = '{0, 1, 2, 3, 7, 12, 15, 28, 112, 240, 65535, 65534,
                           -1, -7, -65535, -65536};
        foreach (words[i]) send_word(VALUE_W'(words[i]));
        await_all_results();
    endtask

    // Negative words, the unrepresentable magnitude and a square in each other mode.
    task automatic test_negative_modes_directed();
        logic [MODE_W-1:0] modes [3] = '{mscc_pkg::MODE_DROP, mscc_pkg::MODE_AS_ZERO,
                                         mscc_pkg::MODE_REPORT};
        foreach (modes[m]) begin
            write_mode(modes[m]);
            send_word(VALUE_W'(-1));
            send_word(VALUE_W'(-65536));
            send_word(VALUE_W'(9));
            await_all_results();
        end
    endtask

    // Random traffic over several mode settings, each phase opening without idling.
    task automatic test_random_traffic();
        logic [MODE_W-1:0] modes [8] = '{mscc_pkg::MODE_IGNORE_SIGN, mscc_pkg::MODE_REPORT,
                                         mscc_pkg::MODE_DROP, mscc_pkg::MODE_AS_ZERO,
                                         mscc_pkg::MODE_REPORT, mscc_pkg::MODE_IGNORE_SIGN,
                                         mscc_pkg::MODE_AS_ZERO, mscc_pkg::MODE_DROP};
        foreach (modes[m]) begin
            write_mode(modes[m]);
            for (int i = 0; i < PHASE_WORDS; i++) begin
                steady_flow = (i < 40);
                send_word(random_word());
            end
            steady_flow = 1'b0;
            await_all_results();
        end
    endtask

    // The sink holds off for a long stretch while words keep coming, so the input stalls.
    task automatic test_output_backpressure();
        hold_request = HOLD_OFF;
        steady_flow  = 1'b1;
        for (int i = 0; i < 16; i++) send_word(random_word());
        steady_flow = 1'b0;
        await_all_results();
    endtask

    // The source pauses mid-stream until every result has come back, then carries on.
    task automatic test_sender_pause();
        for (int i = 0; i < 20; i++) send_word(random_word());
        await_all_results();
        for (int i = 0; i < 20; i++) send_word(random_word());
        await_all_results();
    endtask

    // Result sink: a random stall before each word (none in steady flow), or a long hold-off when asked.
    initial begin : result_sink
        int stall;
        m_ready <= 1'b0;
        while (aresetn !== 1'b1) @(posedge aclk);
        forever begin
            if (hold_request != 0) begin
                stall        = hold_request;
                hold_request = 0;
            end else if (steady_flow) begin
                stall = 0;
            end else begin
                stall = $urandom_range(0, MAX_GAP);
            end
            if (stall != 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!(m_valid && m_ready));
        end
    end

    // Compare every accepted result with the oldest expectation.
    always @(posedge aclk) begin : result_check
        class_result_t want;
        if (aresetn && m_valid && m_ready) begin
            results_seen++;
            if (pending_results.size() == 0) begin
                fault_count++;
                if (fault_count <= 10)
                    $display("Unexpected result word: bin %0d value %0d status %0d",
                             m_bin, m_value_out, m_status);
            end else begin
                want = pending_results.pop_front();
                if (m_bin !== want.bin || m_value_out !== want.value
                        || m_status !== want.status) begin
                    fault_count++;
                    if (fault_count <= 10) begin
                        $display("Result %0d mismatch: expected bin %0d value %0d status %0d",
                                 results_seen, want.bin, want.value, want.status);
                        $display("    got bin %0d value %0d status %0d",
                                 m_bin, m_value_out, m_status);
                    end
                end
                bin_tally[m_bin]++;
                status_tally[m_status]++;
            end
        end
    end

    // Watchdog on cycles in which no channel moves a word.
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("Watchdog: no handshake for %0d cycles, %0d results outstanding",
                         idle_cycles, pending_results.size());
                $display("min_square_count_classifier_unit verification failed");
                $finish;
            end
        end
    end

    // Reset, then the tests in turn, then the verdict.
    initial begin
        for (int k = 0; k * k <= MAG_MAX; k++) square_map[k * k] = 1'b1;
        neg_mode     = mscc_pkg::MODE_IGNORE_SIGN;
        steady_flow  = 1'b0;
        hold_request = 0;
        idle_cycles  = 0;
        aresetn   <= 1'b0;
        cfg_valid <= 1'b0;
        cfg_data  <= mscc_pkg::MODE_IGNORE_SIGN;
        s_valid   <= 1'b0;
        s_value   <= '0;
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_reset_mode_directed();
        test_negative_modes_directed();
        test_random_traffic();
        test_output_backpressure();
        test_sender_pause();
        await_all_results();

        $display("Sent %0d words across %0d mode writes; %0d results checked, %0d faults.",
                 words_sent, mode_writes, results_seen, fault_count);
        $display("Bins 0-4 seen %0d/%0d/%0d/%0d/%0d; classified %0d, dropped %0d, errors %0d.",
                 bin_tally[0], bin_tally[1], bin_tally[2], bin_tally[3], bin_tally[4],
                 status_tally[mscc_pkg::STATUS_OK], status_tally[mscc_pkg::STATUS_DROPPED],
                 status_tally[mscc_pkg::STATUS_ERROR]);
        if (fault_count == 0 && pending_results.size() == 0)
            $display("min_square_count_classifier_unit verification clean");
        else
            $display("min_square_count_classifier_unit verification failed");
        $finish;
    end

endmodule

// File: files.f
hw/rtl/mscc_pkg.sv
hw/rtl/mscc_unit.sv
hw/rtl/mscc_engine.sv
hw/rtl/min_square_count_classifier_unit.sv
test/min_square_count_classifier_unit_test.sv
